FILE: rtl/core/asfr_pkg.sv
// ----------------------------------------------------------------------------
// asfr_pkg
// Shared types and constants of the sensor frame receiver.
// ----------------------------------------------------------------------------
package asfr_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned READING_W   = 16;
	localparam int unsigned PAYLOAD_LEN = 6;
	localparam int unsigned POS_W       = 3;

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h5F;

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [READING_W-1:0] reading_t;

	typedef struct packed {
		logic     frame_ok;
		reading_t voc_tenths_ppm;
		reading_t formaldehyde_hundredths_mg;
		reading_t co2_ppm;
	} result_t;

	// handshake between the input stage and the parser
	typedef struct packed {
		logic  valid;
		byte_t data;
	} in_item_t;

	typedef struct packed {
		logic emit;
		logic step;
	} step_ctl_t;

endpackage

FILE: rtl/core/asfr_in_stage.sv
// ----------------------------------------------------------------------------
// asfr_in_stage
// Input register holding one received byte until the parser steps on it.
// ----------------------------------------------------------------------------
module asfr_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  asfr_pkg::byte_t  rx_byte,
	input  logic             advance,
	output asfr_pkg::in_item_t item
);
	import asfr_pkg::*;

	logic  valid_s1;
	byte_t byte_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	assign item.valid = valid_s1;
	assign item.data  = byte_s1;

endmodule

FILE: rtl/core/asfr_parser.sv
// ----------------------------------------------------------------------------
// asfr_parser
// Frame state machine: header hunt, payload capture, checksum compare.
// ----------------------------------------------------------------------------
module asfr_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  asfr_pkg::in_item_t item,
	input  asfr_pkg::byte_t    header_q,
	input  logic               out_free,
	output asfr_pkg::step_ctl_t ctl,
	output asfr_pkg::result_t  result
);
	import asfr_pkg::*;

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_CSUM    = 2'd2;
	localparam logic [1:0] PH_UNUSED  = 2'd3;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAYLOAD_LEN - 1);

	logic [1:0]       phase_q;
	logic [POS_W-1:0] pos_q;
	byte_t            sum_q;
	byte_t            store_q [PAYLOAD_LEN];
	logic             ok;

	assign ctl.emit = item.valid && (phase_q == PH_CSUM);
	assign ctl.step = item.valid && (!ctl.emit || out_free);

	assign ok = (item.data == sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
			sum_q   <= HEADER_RESET;
		end else if (ctl.step) begin
			unique case (phase_q)
				PH_PAYLOAD: begin
					sum_q <= sum_q + item.data;
					pos_q <= pos_q + 1'b1;
					if (pos_q == POS_LAST) begin
						phase_q <= PH_CSUM;
					end
				end
				PH_CSUM: begin
					phase_q <= PH_HUNT;
					pos_q   <= '0;
				end
				PH_HUNT, PH_UNUSED: begin
					if (item.data == header_q) begin
						phase_q <= PH_PAYLOAD;
						pos_q   <= '0;
						sum_q   <= header_q;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && phase_q == PH_PAYLOAD && pos_q <= POS_LAST) begin
			store_q[pos_q] <= item.data;
		end
	end

	assign result.frame_ok = ok;
	assign result.voc_tenths_ppm =
		ok ? {store_q[0], store_q[1]} : '0;
	assign result.formaldehyde_hundredths_mg =
		ok ? {store_q[2], store_q[3]} : '0;
	assign result.co2_ppm =
		ok ? {store_q[4], store_q[5]} : '0;

	a_no_unused_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_UNUSED)
		else $error("parser entered unused phase");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pos_q <= POS_LAST)
		else $error("payload position out of range");

	a_back_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && ctl.emit |=> phase_q == PH_HUNT && pos_q == '0)
		else $error("parser did not return to hunting after checksum");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit && !out_free |=> $stable(phase_q) && $stable(sum_q))
		else $error("parser state moved while result was blocked");

endmodule

FILE: rtl/core/asfr_out_reg.sv
// ----------------------------------------------------------------------------
// asfr_out_reg
// Result register presenting one frame result to the output channel.
// ----------------------------------------------------------------------------
module asfr_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  asfr_pkg::result_t result,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_ready,
	output asfr_pkg::result_t result_q
);
	import asfr_pkg::*;

	logic valid_q;

	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			result_q <= result;
		end
	end

endmodule

FILE: rtl/core/air_sensor_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// air_sensor_frame_receiver_core
// Recognizes 8-byte sensor frames (header, six payload bytes, checksum) in a
// byte stream and gives one result per frame with three 16-bit readings.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  input    in_valid / in_ready    rx_byte
//  output   out_valid / out_ready  frame_ok, voc_tenths_ppm,
//                                  formaldehyde_hundredths_mg, co2_ppm
//  config   cfg_valid / cfg_ready  header_value
//
//  One byte per cycle while no checksum byte is stalled. A byte is held in the
//  input register, is parsed, and the result of a checksum byte is registered
//  in the result register.
//  Reset: hunting for a header, header register = 0x5F.
//  A full result register stalls only a checksum byte; other bytes still flow.
// ----------------------------------------------------------------------------
module air_sensor_frame_receiver_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  asfr_pkg::byte_t      rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 frame_ok,
	output asfr_pkg::reading_t   voc_tenths_ppm,
	output asfr_pkg::reading_t   formaldehyde_hundredths_mg,
	output asfr_pkg::reading_t   co2_ppm,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  asfr_pkg::byte_t      header_value
);
	import asfr_pkg::*;

	byte_t     header_q;
	in_item_t  item;
	step_ctl_t ctl;
	result_t   result;
	result_t   result_q;
	logic      out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_valid) begin
			header_q <= header_value;
		end
	end

	asfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (ctl.step),
		.item     (item)
	);

	asfr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.header_q (header_q),
		.out_free (out_free),
		.ctl      (ctl),
		.result   (result)
	);

	asfr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (ctl.step && ctl.emit),
		.result    (result),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_q  (result_q)
	);

	assign frame_ok                   = result_q.frame_ok;
	assign voc_tenths_ppm             = result_q.voc_tenths_ppm;
	assign formaldehyde_hundredths_mg = result_q.formaldehyde_hundredths_mg;
	assign co2_ppm                    = result_q.co2_ppm;

endmodule
